// File: rtl/layer_mix_with_trails_macros.svh
// assertion macros for the layer mix block
// each expects signals named clock and reset in the module that uses it
`ifndef LAYER_MIX_WITH_TRAILS_MACROS_SVH
`define LAYER_MIX_WITH_TRAILS_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define LMT_ASSERT_SAME(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("lmt assertion failed");

// next-cycle implication
`define LMT_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("lmt assertion failed");

`else

`define LMT_ASSERT_SAME(name, pre, post)
`define LMT_ASSERT_NEXT(name, pre, post)

`endif

`endif

// File: rtl/lmt_pkg.sv
`default_nettype none

package lmt_pkg;

   // fixed point and sizing
   localparam int FRAC_BITS  = 12;
   localparam int MAX_PIXELS = 256;
   localparam int IDX_W      = $clog2(MAX_PIXELS);
   localparam int CNT_W      = 9;
   localparam int CMP_W      = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

   // field widths
   localparam int CHAN_W  = 12;
   localparam int LEVEL_W = 13;
   localparam int GAIN_W  = 16;
   localparam int OUT_W   = 14;
   localparam int KEEP_W  = 12;
   localparam int OVR_W   = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // constants in Q.12, rounded to nearest
   localparam logic [LEVEL_W-1:0] ONE_Q         = LEVEL_W'(1 << FRAC_BITS);
   localparam logic [KEEP_W-1:0]  KEEP_CALM_Q   = KEEP_W'((85 * (1 << FRAC_BITS) + 50) / 100);
   localparam logic [KEEP_W-1:0]  KEEP_FLOW_Q   = KEEP_W'((60 * (1 << FRAC_BITS) + 50) / 100);
   localparam logic [KEEP_W-1:0]  KEEP_GROOVE_Q = KEEP_W'((35 * (1 << FRAC_BITS) + 50) / 100);
   localparam logic [KEEP_W-1:0]  KEEP_MAX_Q    = KEEP_W'((98 * (1 << FRAC_BITS) + 50) / 100);
   localparam logic [OUT_W-1:0]   FLOOR_Q       = OUT_W'((1 << FRAC_BITS) >> 10);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BREATH_GAIN   = 3'd0,
      CSR_FLOW_GAIN     = 3'd1,
      CSR_GROOVE_GAIN   = 3'd2,
      CSR_KEEP_OVERRIDE = 3'd3,
      CSR_TRAILS_ON     = 3'd4,
      CSR_PIXEL_COUNT   = 3'd5
   } lmt_csr_type;

   typedef struct packed {
      logic [GAIN_W-1:0] breath_gain;
      logic [GAIN_W-1:0] flow_gain;
      logic [GAIN_W-1:0] groove_gain;
      logic [OVR_W-1:0]  keep_override;
      logic              trails_on;
      logic [CNT_W-1:0]  pixel_count;
   } lmt_cfg_type;

   localparam lmt_cfg_type CFG_RESET = '{
      breath_gain:   GAIN_W'(4096),
      flow_gain:     GAIN_W'(4096),
      groove_gain:   GAIN_W'(4096),
      keep_override: {OVR_W{1'b1}},
      trails_on:     1'b1,
      pixel_count:   CNT_W'(256)
   };

   // input word: one pixel
   typedef struct packed {
      logic [CHAN_W-1:0]  breath_red;
      logic [CHAN_W-1:0]  breath_green;
      logic [CHAN_W-1:0]  breath_blue;
      logic [CHAN_W-1:0]  flow_red;
      logic [CHAN_W-1:0]  flow_green;
      logic [CHAN_W-1:0]  flow_blue;
      logic [CHAN_W-1:0]  groove_red;
      logic [CHAN_W-1:0]  groove_green;
      logic [CHAN_W-1:0]  groove_blue;
      logic [LEVEL_W-1:0] calm_level;
      logic [LEVEL_W-1:0] flow_level;
      logic [LEVEL_W-1:0] groove_level;
   } lmt_pix_type;

   // result word
   typedef struct packed {
      logic [OUT_W-1:0] red_out;
      logic [OUT_W-1:0] green_out;
      logic [OUT_W-1:0] blue_out;
   } lmt_rgb_type;

   // three channels, index 0 is red
   typedef logic [2:0][OUT_W-1:0] lmt_trail_type;

   // mix pipeline output at its last stage
   typedef struct packed {
      lmt_trail_type     live;
      logic [KEEP_W-1:0] keep;
   } lmt_mix_type;

   // pipeline control shared by the stages
   typedef struct packed {
      logic adv;
      logic s1_valid;
      logic s2_valid;
      logic s3_valid;
   } lmt_ctl_type;

endpackage

`default_nettype wire

// File: rtl/lmt_ifs.sv
`default_nettype none

// pixel channel
interface lmt_req_if
   import lmt_pkg::*;
();
   logic        valid;
   logic        ready;
   lmt_pix_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface lmt_rsp_if
   import lmt_pkg::*;
();
   logic        valid;
   logic        ready;
   lmt_rgb_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/lmt_ram.sv
`default_nettype none

module lmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port, read returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/lmt_mix.sv
`default_nettype none

module lmt_mix
   import lmt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire lmt_pix_type pix,
   input  wire lmt_cfg_type cfg,
   output lmt_mix_type      mix
);

   localparam int WPROD_W = LEVEL_W + GAIN_W;
   localparam int WSH_W   = WPROD_W - FRAC_BITS;
   localparam int KPROD_W = KEEP_W + LEVEL_W;
   localparam int KSUM_W  = KPROD_W + 2;
   localparam int KSEL_W  = KSUM_W - FRAC_BITS;
   localparam int MPROD_W = CHAN_W + LEVEL_W;
   localparam int LSUM_W  = MPROD_W + 2;

   // stage 1: layer colors, level*gain, mood keep terms
   logic [2:0][2:0][CHAN_W-1:0] s1_col_ff, s1_col_in;
   logic [2:0][WPROD_W-1:0]     s1_wprod_ff, s1_wprod_in;
   logic [2:0][KPROD_W-1:0]     s1_kprod_ff, s1_kprod_in;
   // stage 2: weighted colors, final keep
   logic [2:0][2:0][MPROD_W-1:0] s2_mprod_ff, s2_mprod_in;
   logic [KEEP_W-1:0]            s2_keep_ff, s2_keep_in;
   // stage 3: live mix
   lmt_trail_type                s3_live_ff, s3_live_in;
   logic [KEEP_W-1:0]            s3_keep_ff;

   logic [2:0][WSH_W-1:0]   wsh;
   logic [2:0][LEVEL_W-1:0] weight;
   logic [KSUM_W-1:0]       ksum;
   logic [KSEL_W-1:0]       kmood;
   logic [KSEL_W-1:0]       ksel;
   logic [LSUM_W-1:0]       lsum [3];

   // stage 1 products
   always_comb begin
      s1_col_in[0] = {pix.breath_blue, pix.breath_green, pix.breath_red};
      s1_col_in[1] = {pix.flow_blue, pix.flow_green, pix.flow_red};
      s1_col_in[2] = {pix.groove_blue, pix.groove_green, pix.groove_red};
      s1_wprod_in[0] = WPROD_W'(pix.calm_level) * WPROD_W'(cfg.breath_gain);
      s1_wprod_in[1] = WPROD_W'(pix.flow_level) * WPROD_W'(cfg.flow_gain);
      s1_wprod_in[2] = WPROD_W'(pix.groove_level) * WPROD_W'(cfg.groove_gain);
      s1_kprod_in[0] = KPROD_W'(KEEP_CALM_Q) * KPROD_W'(pix.calm_level);
      s1_kprod_in[1] = KPROD_W'(KEEP_FLOW_Q) * KPROD_W'(pix.flow_level);
      s1_kprod_in[2] = KPROD_W'(KEEP_GROOVE_Q) * KPROD_W'(pix.groove_level);
   end

   // stage 2: clamp weights to one, weight colors, pick and clamp keep
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         wsh[l] = s1_wprod_ff[l][WPROD_W-1:FRAC_BITS];
         weight[l] = (wsh[l] > WSH_W'(ONE_Q)) ? ONE_Q : wsh[l][LEVEL_W-1:0];
         for (int c = 0; c < 3; c++) begin
            s2_mprod_in[l][c] = MPROD_W'(s1_col_ff[l][c]) * MPROD_W'(weight[l]);
         end
      end
      ksum = KSUM_W'(s1_kprod_ff[0]) + KSUM_W'(s1_kprod_ff[1]) + KSUM_W'(s1_kprod_ff[2]);
      kmood = ksum[KSUM_W-1:FRAC_BITS];
      // negative override selects the mood keep
      ksel = cfg.keep_override[OVR_W-1] ? kmood : KSEL_W'(cfg.keep_override);
      s2_keep_in = (ksel > KSEL_W'(KEEP_MAX_Q)) ? KEEP_MAX_Q : ksel[KEEP_W-1:0];
   end

   // stage 3: sum the three layers per channel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         lsum[c] = LSUM_W'(s2_mprod_ff[0][c]) + LSUM_W'(s2_mprod_ff[1][c]) +
                   LSUM_W'(s2_mprod_ff[2][c]);
         s3_live_in[c] = lsum[c][FRAC_BITS+OUT_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff   <= s1_col_in;
         s1_wprod_ff <= s1_wprod_in;
         s1_kprod_ff <= s1_kprod_in;
         s2_mprod_ff <= s2_mprod_in;
         s2_keep_ff  <= s2_keep_in;
         s3_live_ff  <= s3_live_in;
         s3_keep_ff  <= s2_keep_ff;
      end
   end

   assign mix.live = s3_live_ff;
   assign mix.keep = s3_keep_ff;

endmodule

`default_nettype wire

// File: rtl/lmt_trail.sv
`default_nettype none
`include "layer_mix_with_trails_macros.svh"

module lmt_trail
   import lmt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lmt_ctl_type      ctl,
   input  wire logic [IDX_W-1:0] acc_idx,
   input  wire logic             trails_on,
   input  wire lmt_mix_type      mix,
   output lmt_rgb_type           res
);

   localparam int DPROD_W = OUT_W + KEEP_W;
   localparam int TRAIL_W = 3 * OUT_W;

   logic [IDX_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic             s1_entv_ff;
   logic             s1_hit_ff;
   lmt_trail_type    s1_hitval_ff;
   lmt_trail_type    s2_trail_ff, s2_trail_in;
   lmt_trail_type    s3_trail_ff, s3_trail_in;
   logic             ent_valid_ff [MAX_PIXELS];
   lmt_trail_type    ram_q;

   logic                       wr;
   logic [2:0][DPROD_W-1:0]    dprod;
   lmt_trail_type              dec;
   lmt_trail_type              tnew;
   lmt_trail_type              upd;
   lmt_trail_type              outv;

   assign wr = ctl.adv && ctl.s3_valid;

   // trail update: decay, drop small tails, max with live
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dprod[c] = DPROD_W'(s3_trail_ff[c]) * DPROD_W'(mix.keep);
         dec[c] = dprod[c][FRAC_BITS+OUT_W-1:FRAC_BITS];
         if (dec[c] < FLOOR_Q) begin
            dec[c] = '0;
         end
         tnew[c] = (mix.live[c] > dec[c]) ? mix.live[c] : dec[c];
         upd[c] = trails_on ? tnew[c] : '0;
         outv[c] = trails_on ? tnew[c] : mix.live[c];
      end
   end

   assign res.red_out   = outv[0];
   assign res.green_out = outv[1];
   assign res.blue_out  = outv[2];

   // forward the entry being written to younger words with the same index
   always_comb begin
      if (wr && s1_idx_ff == s3_idx_ff) begin
         s2_trail_in = upd;
      end else if (s1_hit_ff) begin
         s2_trail_in = s1_hitval_ff;
      end else if (s1_entv_ff) begin
         s2_trail_in = ram_q;
      end else begin
         s2_trail_in = '0;
      end
      s3_trail_in = (wr && s2_idx_ff == s3_idx_ff) ? upd : s2_trail_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         s1_idx_ff    <= acc_idx;
         s1_entv_ff   <= ent_valid_ff[acc_idx];
         s1_hit_ff    <= wr && (acc_idx == s3_idx_ff);
         s1_hitval_ff <= upd;
         s2_idx_ff    <= s1_idx_ff;
         s2_trail_ff  <= s2_trail_in;
         s3_idx_ff    <= s2_idx_ff;
         s3_trail_ff  <= s3_trail_in;
      end
   end

   // entry written flags, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PIXELS; i++) begin
            ent_valid_ff[i] <= 1'b0;
         end
      end else if (wr) begin
         ent_valid_ff[s3_idx_ff] <= 1'b1;
      end
   end

   lmt_ram #(
      .WIDTH (TRAIL_W),
      .DEPTH (MAX_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr),
      .wr_addr (s3_idx_ff),
      .wr_data (upd),
      .rd_en   (ctl.adv),
      .rd_addr (acc_idx),
      .rd_data (ram_q)
   );

   `LMT_ASSERT_NEXT(a_fwd_s3, wr && ctl.s2_valid && s2_idx_ff == s3_idx_ff, s3_trail_ff == $past(upd))
   `LMT_ASSERT_NEXT(a_entry_marked, wr, ent_valid_ff[$past(s3_idx_ff)])
   `LMT_ASSERT_SAME(a_trail_floor, ctl.s3_valid && trails_on, res.red_out >= mix.live[0] && res.blue_out >= mix.live[2])

endmodule

`default_nettype wire

// File: rtl/layer_mix_with_trails.sv
// channel  | dir | word                                  | handshake
// req_if   | in  | three layer colors, three mood levels | valid/ready
// rsp_if   | out | red, green, blue after mix and trail  | valid/ready
// csr_*    | in  | register index and data               | write enable only
//
// one pixel per clock while results are taken; each goes via s1-s3 to o_data_ff
// the rate is set by the trail update loop: one multiply per channel per clock,
// with the written entry forwarded to younger pixels at the same position
// reset is synchronous; trail entries read as zero until written, no clear pass
// while a result waits the skid stage takes one more word, then the input stalls
`default_nettype none
`include "layer_mix_with_trails_macros.svh"

module layer_mix_with_trails
   import lmt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   lmt_req_if.sink                    req_if,
   lmt_rsp_if.source                  rsp_if,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   lmt_cfg_type      cfg_ff, cfg_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic             o_valid_ff, o_valid_in;
   lmt_rgb_type      o_data_ff, o_data_in;
   logic             sk_valid_ff, sk_valid_in;
   lmt_rgb_type      sk_data_ff;

   logic             adv;
   logic             accept;
   logic             produce;
   logic [CMP_W-1:0] count_eff;
   logic [IDX_W-1:0] idx;
   logic [CMP_W-1:0] idx_next;
   lmt_ctl_type      ctl;
   lmt_mix_type      mix;
   lmt_rgb_type      res;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (lmt_csr_type'(csr_index))
            CSR_BREATH_GAIN:   cfg_in.breath_gain   = csr_wdata;
            CSR_FLOW_GAIN:     cfg_in.flow_gain     = csr_wdata;
            CSR_GROOVE_GAIN:   cfg_in.groove_gain   = csr_wdata;
            CSR_KEEP_OVERRIDE: cfg_in.keep_override = csr_wdata[OVR_W-1:0];
            CSR_TRAILS_ON:     cfg_in.trails_on     = csr_wdata[0];
            CSR_PIXEL_COUNT:   cfg_in.pixel_count   = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advances unless the skid stage is holding a word
   assign adv     = !sk_valid_ff;
   assign accept  = req_if.valid && adv;
   assign produce = adv && s3_valid_ff;

   // pixel position with wrap at the frame length
   always_comb begin
      if (cfg_ff.pixel_count == '0) begin
         count_eff = CMP_W'(1);
      end else if (CMP_W'(cfg_ff.pixel_count) > CMP_W'(MAX_PIXELS)) begin
         count_eff = CMP_W'(MAX_PIXELS);
      end else begin
         count_eff = CMP_W'(cfg_ff.pixel_count);
      end
      idx = (CMP_W'(pos_ff) >= count_eff) ? '0 : pos_ff;
      idx_next = CMP_W'(idx) + CMP_W'(1);
      pos_in = (idx_next >= count_eff) ? '0 : idx_next[IDX_W-1:0];
   end

   assign ctl.adv      = adv;
   assign ctl.s1_valid = s1_valid_ff;
   assign ctl.s2_valid = s2_valid_ff;
   assign ctl.s3_valid = s3_valid_ff;

   lmt_mix u_mix (
      .clock (clock),
      .adv   (adv),
      .pix   (req_if.data),
      .cfg   (cfg_ff),
      .mix   (mix)
   );

   lmt_trail u_trail (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .acc_idx   (idx),
      .trails_on (cfg_ff.trails_on),
      .mix       (mix),
      .res       (res)
   );

   // output register with skid stage
   always_comb begin
      o_valid_in  = o_valid_ff;
      o_data_in   = o_data_ff;
      sk_valid_in = sk_valid_ff;
      if (!o_valid_ff || rsp_if.ready) begin
         if (sk_valid_ff) begin
            o_valid_in  = 1'b1;
            o_data_in   = sk_data_ff;
            sk_valid_in = 1'b0;
         end else begin
            o_valid_in = produce;
            o_data_in  = res;
         end
      end else if (produce) begin
         sk_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
         sk_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         o_valid_ff  <= o_valid_in;
         sk_valid_ff <= sk_valid_in;
         if (accept) begin
            pos_ff <= pos_in;
         end
         if (adv) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // result words, no reset needed
   always_ff @(posedge clock) begin
      o_data_ff <= o_data_in;
      if (produce && o_valid_ff && !rsp_if.ready) begin
         sk_data_ff <= res;
      end
   end

   assign req_if.ready = adv;
   assign rsp_if.valid = o_valid_ff;
   assign rsp_if.data  = o_data_ff;

   `LMT_ASSERT_SAME(a_skid_behind_out, sk_valid_ff, o_valid_ff)
   `LMT_ASSERT_NEXT(a_skid_catch, produce && o_valid_ff && !rsp_if.ready, sk_valid_ff && o_valid_ff)
   `LMT_ASSERT_NEXT(a_pos_moves, accept && count_eff != CMP_W'(1), pos_ff != $past(pos_ff))

endmodule

`default_nettype wire
